// File: src/urfd_pkg.sv
// Shared types and constants for the UART receive-ring register block.
package urfd_pkg;

    // Item operation codes
    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_DATA    = 2'd0;
    localparam logic [1:0] REG_STATUS  = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;

    // Control word bit positions
    localparam int CTRL_RX_IE = 0;
    localparam int CTRL_TX_IE = 1;
    localparam int CTRL_RESET = 2;

    // Status bit positions
    localparam int ST_RX_READY = 0;
    localparam int ST_TX_EMPTY = 1;
    localparam int ST_OVERFLOW = 2;
    localparam int ST_RX_FULL  = 3;

    localparam int          STATUS_W      = 4;
    localparam logic [3:0]  STATUS_RESET  = 4'b0010;
    localparam int          FULL_MARGIN   = 4;
    localparam logic [31:0] TX_BYTE_MASK  = 32'h0000_00FF;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  reg_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } urfd_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
    } urfd_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
    } urfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_hit;
    } urfd_stat_t;

endpackage

// File: src/urfd_ctrl.sv
// Sequencing state machine for the UART receive-ring register block.
module urfd_ctrl
    import urfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  urfd_stat_t stat,
    output urfd_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load  = in_valid && in_ready_reg;
        cmd.exec  = (state_reg == S_EXEC);
        cmd.fetch = (state_reg == S_FETCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    // a data pop goes through S_FETCH for the registered ring read
                    if (stat.pop_hit)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        state_reg     <= S_HOLD;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_FETCH:
                begin
                    state_reg     <= S_HOLD;
                    out_valid_reg <= 1'b1;
                end
                S_HOLD:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                    in_ready_reg  <= 1'b1;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted item not executed");

    a_fetch_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> $past(cmd.exec && stat.pop_hit))
        else $error("fetch without a pop");
`endif

endmodule

// File: src/urfd_datapath.sv
// Registers, receive ring and result register of the UART register block.
module urfd_datapath
    import urfd_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  urfd_in_t   in_data,
    input  urfd_cmd_t  cmd,
    output urfd_stat_t stat,
    output urfd_out_t  out_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [PTR_W:0]   FULL_LVL  = (PTR_W + 1)'(RING_DEPTH - FULL_MARGIN);

    logic [7:0] ring [RING_DEPTH];
    logic [7:0] mem_q_reg;

    urfd_in_t            item_reg;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [31:0]         ctrl_reg, ctrl_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    urfd_out_t           res_reg, res_next;

    logic             ring_we;
    logic             ring_re;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W:0]   held;
    logic             is_data_read;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign wp_inc       = ptr_inc(wp_reg);
    assign rp_inc       = ptr_inc(rp_reg);
    assign is_data_read = (item_reg.op == OP_READ) && (item_reg.reg_index == REG_DATA);
    assign stat.pop_hit = is_data_read && (rp_reg != wp_reg);

    // fill level after an arrival
    always_comb
    begin
        if (wp_inc >= rp_reg)
            held = {1'b0, wp_inc} - {1'b0, rp_reg};
        else
            held = {1'b0, wp_inc} + DEPTH_EXT - {1'b0, rp_reg};
    end

    always_comb
    begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        ctrl_next = ctrl_reg;
        st_next   = st_reg;
        ring_we   = 1'b0;
        ring_re   = 1'b0;
        res_next  = '0;
        case (item_reg.op)
            OP_RX:
            begin
                if (wp_inc == rp_reg)
                begin
                    // ring full: drop the byte
                    st_next[ST_OVERFLOW] = 1'b1;
                end
                else
                begin
                    ring_we              = 1'b1;
                    wp_next              = wp_inc;
                    st_next[ST_RX_READY] = 1'b1;
                    if (held > FULL_LVL)
                        st_next[ST_RX_FULL] = 1'b1;
                end
            end
            OP_READ:
            begin
                case (item_reg.reg_index)
                    REG_DATA:
                    begin
                        if (rp_reg != wp_reg)
                        begin
                            ring_re = 1'b1;
                            rp_next = rp_inc;
                            if (rp_inc == wp_reg)
                                st_next[ST_RX_READY] = 1'b0;
                            st_next[ST_RX_FULL] = 1'b0;
                        end
                    end
                    REG_STATUS:  res_next.read_data = 32'(st_reg);
                    REG_CONTROL: res_next.read_data = ctrl_reg;
                    default:     res_next.read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (item_reg.reg_index)
                    REG_DATA:
                    begin
                        res_next.tx_valid    = 1'b1;
                        res_next.tx_byte     = 8'(item_reg.write_data & TX_BYTE_MASK);
                        st_next[ST_TX_EMPTY] = 1'b1;
                    end
                    REG_CONTROL:
                    begin
                        ctrl_next = item_reg.write_data;
                        if (item_reg.write_data[CTRL_RESET])
                        begin
                            rp_next               = '0;
                            wp_next               = '0;
                            st_next               = STATUS_RESET;
                            ctrl_next[CTRL_RESET] = 1'b0;
                        end
                    end
                    default:
                    begin
                        ctrl_next = ctrl_reg;
                    end
                endcase
            end
            default:
            begin
                res_next = '0;
            end
        endcase
        res_next.irq = (ctrl_next[CTRL_RX_IE] && st_next[ST_RX_READY]) ||
                       (ctrl_next[CTRL_TX_IE] && st_next[ST_TX_EMPTY]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && ring_we)
            ring[wp_reg] <= item_reg.rx_byte;
        if (cmd.exec && ring_re)
            mem_q_reg <= ring[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.exec)
            res_reg <= res_next;
        else if (cmd.fetch)
            res_reg.read_data <= 32'(mem_q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            ctrl_reg <= '0;
            st_reg   <= STATUS_RESET;
        end
        else if (cmd.exec)
        begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            ctrl_reg <= ctrl_next;
            st_reg   <= st_next;
        end
    end

    assign out_data = res_reg;

`ifndef SYNTHESIS
    a_tx_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[ST_TX_EMPTY])
        else $error("tx empty bit lost");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= PTR_LAST) && (wp_reg <= PTR_LAST))
        else $error("ring pointer out of range");

    a_ready_tracks_ring: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[ST_RX_READY] == (rp_reg != wp_reg))
        else $error("rx ready disagrees with ring pointers");
`endif

endmodule

// File: src/uart_rx_fifo_device.sv
// Sequencing: the controller runs one item at a time through execute, optional
//   ring read (fetch, on a data pop), then result hold; it takes no new item
//   until the held result is taken with out_ready.
// The ring read port is registered, which is why a pop needs the fetch state.
// Reset: rst_n asynchronous active low; pointers and control word clear, status
//   holds tx empty only; ring contents and result register (irq) are not cleared.
module uart_rx_fifo_device
    import urfd_pkg::*;
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  urfd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output urfd_out_t out_data
);

    urfd_cmd_t  cmd;
    urfd_stat_t stat;

    urfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    urfd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
